>>> rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/msialu_pkg.sv
`timescale 1ns / 1ps
package msialu_pkg;

  localparam int LANES_DEF     = 2;
  localparam int LANE_BITS_DEF = 32;
  localparam int VEC_W         = 64;
  localparam int MASK_W        = 2;
  localparam int OP_W          = 5;
  localparam int SCALAR_W      = 32;
  localparam int DIV_STEP      = 4;

  localparam logic [OP_W-1:0] OP_SET        = 5'd0;
  localparam logic [OP_W-1:0] OP_MOVE       = 5'd1;
  localparam logic [OP_W-1:0] OP_ADD        = 5'd2;
  localparam logic [OP_W-1:0] OP_SUB        = 5'd3;
  localparam logic [OP_W-1:0] OP_MUL        = 5'd4;
  localparam logic [OP_W-1:0] OP_DIV        = 5'd5;
  localparam logic [OP_W-1:0] OP_ABS        = 5'd6;
  localparam logic [OP_W-1:0] OP_GT         = 5'd7;
  localparam logic [OP_W-1:0] OP_LT         = 5'd8;
  localparam logic [OP_W-1:0] OP_EQ         = 5'd9;
  localparam logic [OP_W-1:0] OP_NOT        = 5'd10;
  localparam logic [OP_W-1:0] OP_OR         = 5'd11;
  localparam logic [OP_W-1:0] OP_AND        = 5'd12;
  localparam logic [OP_W-1:0] OP_COUNT      = 5'd13;
  localparam logic [OP_W-1:0] OP_HADD       = 5'd14;
  localparam logic [OP_W-1:0] OP_INTERLEAVE = 5'd15;
  localparam logic [OP_W-1:0] OP_FIRSTN     = 5'd16;

  typedef struct packed {
    logic [OP_W-1:0]            opcode;
    logic [VEC_W-1:0]           vector_a;
    logic [VEC_W-1:0]           vector_b;
    logic [VEC_W-1:0]           old_vector;
    logic [MASK_W-1:0]          lane_mask;
    logic [MASK_W-1:0]          second_mask;
    logic [MASK_W-1:0]          old_result_mask;
    logic signed [SCALAR_W-1:0] scalar_value;
  } msialu_in_t;

  typedef struct packed {
    logic [VEC_W-1:0]  result_vector;
    logic [MASK_W-1:0] result_mask;
    logic [1:0]        bit_count;
    logic              divide_by_zero;
  } msialu_out_t;

endpackage

>>> rtl/msialu_div.sv
`timescale 1ns / 1ps
module msialu_div import msialu_pkg::*; #(
  parameter int W = LANE_BITS_DEF
) (
  input  logic         clk,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient
);

  localparam int NST = (W + DIV_STEP - 1) / DIV_STEP;
  localparam int PW  = NST * DIV_STEP;

  logic [W-1:0]  rem_r [NST];
  logic [PW-1:0] nq_r  [NST];
  logic [W-1:0]  den_r [NST];

  // Restoring division: each stage retires DIV_STEP quotient bits. The dividend
  // shifts out of the top of nq while quotient bits shift in at the bottom.
  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [W-1:0]  rem_nxt;
    logic [PW-1:0] nq_nxt;
    logic [W-1:0]  den_in;

    always_comb begin
      logic [W:0] trial;
      if (s == 0) begin
        rem_nxt = '0;
        nq_nxt  = PW'(dividend);
        den_in  = divisor;
      end else begin
        rem_nxt = rem_r[s-1];
        nq_nxt  = nq_r[s-1];
        den_in  = den_r[s-1];
      end
      for (int k = 0; k < DIV_STEP; k++) begin
        trial  = {rem_nxt, nq_nxt[PW-1]};
        nq_nxt = {nq_nxt[PW-2:0], 1'b0};
        if (trial >= {1'b0, den_in}) begin
          trial     = trial - {1'b0, den_in};
          nq_nxt[0] = 1'b1;
        end
        rem_nxt = trial[W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt;
      nq_r[s]  <= nq_nxt;
      den_r[s] <= den_in;
    end
  end

  assign quotient = nq_r[NST-1][W-1:0];

endmodule

>>> rtl/masked_simd_integer_alu_unit.sv
`timescale 1ns / 1ps
// Masked SIMD integer ALU. A word is taken whenever start is high; busy is never
// raised, so one instruction can be issued every clock cycle. Each result
// appears on out_data with out_valid high for exactly one cycle, after the word
// has passed the input register, the divider stages and the output register,
// in issue order. The depth is set by the lane divider, which resolves four
// quotient bits per pipeline stage; all other operations travel alongside it.
module masked_simd_integer_alu_unit import msialu_pkg::*; #(
  parameter int LANES     = LANES_DEF,
  parameter int LANE_BITS = LANE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  msialu_in_t  in_data,
  output logic        out_valid,
  output msialu_out_t out_data
);

  localparam int NST     = (LANE_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int LATENCY = NST + 2;
  localparam logic [MASK_W-1:0] MMASK = MASK_W'((1 << LANES) - 1);

  typedef struct packed {
    logic [VEC_W-1:0]  vres;
    logic [MASK_W-1:0] mres;
    logic [1:0]        cnt;
    logic              dz;
    logic [LANES-1:0]  div_act;
    logic [LANES-1:0]  div_neg;
    logic [LANES-1:0]  div_zero;
  } part_t;

  msialu_in_t     in_r;
  logic           v1_r;
  part_t          part_nxt;
  part_t          dl_r  [NST];
  logic           dlv_r [NST];
  logic [LANE_BITS-1:0] dnum [LANES];
  logic [LANE_BITS-1:0] dden [LANES];
  logic [LANE_BITS-1:0] quot [LANES];
  msialu_out_t    out_nxt;
  msialu_out_t    out_r;
  logic           out_valid_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    if (start && !busy) begin
      in_r <= in_data;
    end
  end

  // First stage: everything except the quotient itself, including the multiply.
  always_comb begin
    logic [LANE_BITS-1:0] ua, ub, x, s;
    logic [MASK_W-1:0]    em;
    logic                 act, wr;
    logic signed [SCALAR_W-1:0] scs;
    int src;
    em  = in_r.lane_mask & MMASK;
    scs = in_r.scalar_value;
    part_nxt = '0;
    part_nxt.mres = in_r.old_result_mask & MMASK;
    for (int i = 0; i < LANES; i++) begin
      part_nxt.vres[i*LANE_BITS +: LANE_BITS] = in_r.old_vector[i*LANE_BITS +: LANE_BITS];
    end
    for (int i = 0; i < LANES; i++) begin
      ua  = in_r.vector_a[i*LANE_BITS +: LANE_BITS];
      ub  = in_r.vector_b[i*LANE_BITS +: LANE_BITS];
      act = em[i];
      x   = '0;
      wr  = 1'b1;
      dnum[i] = ua[LANE_BITS-1] ? -ua : ua;
      dden[i] = ub[LANE_BITS-1] ? -ub : ub;
      part_nxt.div_neg[i]  = ua[LANE_BITS-1] ^ ub[LANE_BITS-1];
      part_nxt.div_zero[i] = (ub == '0);
      case (in_r.opcode)
        OP_SET:  x = scs[LANE_BITS-1:0];
        OP_MOVE: x = ub;
        OP_ADD:  x = ua + ub;
        OP_SUB:  x = ua - ub;
        OP_MUL:  x = ua * ub;
        OP_ABS:  x = ua[LANE_BITS-1] ? -ua : ua;
        default: wr = 1'b0;
      endcase
      if (wr && act) begin
        part_nxt.vres[i*LANE_BITS +: LANE_BITS] = x;
      end
      if (in_r.opcode == OP_DIV && act) begin
        part_nxt.div_act[i] = 1'b1;
        if (ub == '0) begin
          part_nxt.dz = 1'b1;
        end
      end
      if (act) begin
        case (in_r.opcode)
          OP_GT:   part_nxt.mres[i] = ($signed(ua) > $signed(ub));
          OP_LT:   part_nxt.mres[i] = ($signed(ua) < $signed(ub));
          OP_EQ:   part_nxt.mres[i] = (ua == ub);
          default: ;
        endcase
      end
    end
    case (in_r.opcode)
      OP_NOT: part_nxt.mres = ~em & MMASK;
      OP_OR:  part_nxt.mres = (em | in_r.second_mask) & MMASK;
      OP_AND: part_nxt.mres = (em & in_r.second_mask) & MMASK;
      OP_COUNT: part_nxt.cnt = 2'(em[0]) + 2'(em[1]);
      OP_HADD: begin
        for (int i = 0; i + 1 < LANES; i += 2) begin
          s = in_r.vector_a[i*LANE_BITS +: LANE_BITS]
            + in_r.vector_a[(i+1)*LANE_BITS +: LANE_BITS];
          part_nxt.vres[i*LANE_BITS +: LANE_BITS]     = s;
          part_nxt.vres[(i+1)*LANE_BITS +: LANE_BITS] = s;
        end
      end
      OP_INTERLEAVE: begin
        for (int i = 0; i < LANES; i++) begin
          src = (i < LANES / 2) ? (2 * i) : (2 * (i - LANES / 2) + 1);
          if (src < LANES) begin
            part_nxt.vres[i*LANE_BITS +: LANE_BITS] =
              in_r.vector_a[src*LANE_BITS +: LANE_BITS];
          end
        end
      end
      OP_FIRSTN: begin
        part_nxt.mres = '0;
        for (int i = 0; i < LANES; i++) begin
          part_nxt.mres[i] = (scs > $signed(SCALAR_W'(i)));
        end
      end
      default: ;
    endcase
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    msialu_div #(.W(LANE_BITS)) u_div (
      .clk      (clk),
      .dividend (dnum[g]),
      .divisor  (dden[g]),
      .quotient (quot[g])
    );
  end

  // The partial result rides along while the dividers run.
  always_ff @(posedge clk) begin
    for (int s = 0; s < NST; s++) begin
      if (!rst_n) begin
        dlv_r[s] <= 1'b0;
      end else begin
        dlv_r[s] <= (s == 0) ? v1_r : dlv_r[(s == 0) ? 0 : s - 1];
      end
      dl_r[s] <= (s == 0) ? part_nxt : dl_r[(s == 0) ? 0 : s - 1];
    end
  end

  always_comb begin
    part_t p;
    logic [LANE_BITS-1:0] q;
    p = dl_r[NST-1];
    out_nxt.result_vector  = p.vres;
    out_nxt.result_mask    = p.mres;
    out_nxt.bit_count      = p.cnt;
    out_nxt.divide_by_zero = p.dz;
    for (int i = 0; i < LANES; i++) begin
      q = p.div_neg[i] ? -quot[i] : quot[i];
      if (p.div_act[i]) begin
        out_nxt.result_vector[i*LANE_BITS +: LANE_BITS] = p.div_zero[i] ? '0 : q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dlv_r[NST-1];
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/msialu_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module msialu_checker import msialu_pkg::*; #(
  parameter int LANES = LANES_DEF,
  parameter int LAT   = 10
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input msialu_in_t  in_data,
  input logic        out_valid,
  input msialu_out_t out_data
);

  // Every result word traces back to a word taken a fixed latency earlier.
  `ASSERT_IMPLIES(a_result_has_source, clk, rst_n, out_valid, $past(start && !busy, LAT))
  `ASSERT_IMPLIES(a_count_only_for_count, clk, rst_n,
                  out_valid && (out_data.bit_count != 2'd0),
                  $past(in_data.opcode, LAT) == OP_COUNT)
  `ASSERT_IMPLIES(a_dz_only_for_div, clk, rst_n,
                  out_valid && out_data.divide_by_zero,
                  $past(in_data.opcode, LAT) == OP_DIV)
  `ASSERT_NEXT(a_mask_in_lanes, clk, rst_n, 1'b1,
               !out_valid || ((out_data.result_mask >> LANES) == '0))

endmodule

bind masked_simd_integer_alu_unit msialu_checker #(
  .LANES (LANES),
  .LAT   (LATENCY)
) u_msialu_checker (.*);
